// ===== design/nmea_sfp_pkg.sv =====
package nmea_sfp_pkg;

	// characters of the sentence syntax
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;

	// field index before the first comma
	localparam logic [4:0] NO_FIELD  = 5'd31;
	localparam logic [4:0] POS_MAX   = 5'd31;
	localparam logic [2:0] HDR_BYTES = 3'd5;

	// event kinds
	localparam logic [2:0] EV_NONE  = 3'd0;
	localparam logic [2:0] EV_CHAR  = 3'd1;
	localparam logic [2:0] EV_END   = 3'd2;
	localparam logic [2:0] EV_SUM   = 3'd3;
	localparam logic [2:0] EV_ABORT = 3'd4;

	// configuration register indexes
	localparam logic [1:0] REG_SENTENCE_CODE = 2'd0;
	localparam logic [1:0] REG_FIELD_LIMIT   = 2'd1;
	localparam logic [1:0] REG_CHAR_LIMIT    = 2'd2;

	localparam logic [31:0] SENTENCE_CODE_RST = 32'h434D5250;
	localparam logic [4:0]  FIELD_LIMIT_RST   = 5'd13;
	localparam logic [4:0]  CHAR_LIMIT_RST    = 5'd16;

	typedef struct packed {
		logic        active;
		logic [2:0]  header_count;
		logic [31:0] type_word;
		logic        type_ok;
		logic [4:0]  field_index;
		logic [4:0]  char_index;
		logic        in_checksum;
		logic        hex_high_seen;
		logic [7:0]  received_sum;
		logic [7:0]  running_sum;
	} sfp_state_t;

	typedef struct packed {
		logic [2:0] event_kind;
		logic [4:0] field_number;
		logic [4:0] char_position;
		logic [7:0] char_value;
		logic       checksum_match;
		logic [7:0] computed_sum;
	} sfp_result_t;

	localparam sfp_state_t ST_CLEAR = '{
		active:        1'b0,
		header_count:  3'd0,
		type_word:     32'd0,
		type_ok:       1'b0,
		field_index:   NO_FIELD,
		char_index:    5'd0,
		in_checksum:   1'b0,
		hex_high_seen: 1'b0,
		received_sum:  8'd0,
		running_sum:   8'd0
	};

	// hex digit decode, bit 4 set when the byte is a valid digit
	function automatic logic [4:0] hex_decode(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r = {1'b1, b[3:0]};
		end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
			r = {1'b1, b[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

// ===== design/nmea_sentence_field_parser.sv =====
// Parses a stream of received serial characters, one byte per request, as
// NMEA-0183 style sentences. A '$' starts a sentence; after the talker byte,
// the four type bytes (first type byte in the low byte) are compared with
// sentence_code, and only a matching sentence is reported. Every field
// character then comes out with its field number and position, every ',' or
// '*' reports the end of the field it closes, and after the two hex digits
// that follow '*' a checksum result tells whether they match the XOR of all
// bytes between '$' and '*'. Too many fields, an overlong field, a character
// before the first comma, CR/LF inside a field or a bad checksum digit give a
// sentence-aborted event. Every input byte yields exactly one result request,
// event kind 0 with an all-zero payload when nothing is to be reported. The
// block takes one byte per clock cycle while the sink does not stall. A byte
// sits in the input register until the result slot is free or drained, and
// its result is then offered from the result register. The rate is set by
// the per-byte update of the sentence state; a stalled sink first holds the
// result register, then the input register, and only then stops taking
// bytes. Write configuration only while no byte is in flight.
module nmea_sentence_field_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [4:0] field_number, [9:5] char_position,
	                               // [17:10] char_value, [18] checksum_match,
	                               // [26:19] computed_sum, [31:27] zero
	output logic [2:0]  m_tuser,   // [2:0] event_kind
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import nmea_sfp_pkg::*;

	// configuration registers
	logic [31:0] sentence_code_q;
	logic [4:0]  field_limit_q;
	logic [4:0]  char_limit_q;

	// input stage
	logic        valid_s1;
	logic [7:0]  byte_s1;

	// sentence state
	sfp_state_t  st_q;
	sfp_state_t  nxt;

	// result stage
	logic        valid_s2;
	sfp_result_t res;
	sfp_result_t res_s2;

	logic        advance;
	logic [4:0]  hex;
	logic [4:0]  byte_sel;
	logic [5:0]  field_inc;
	logic [7:0]  sum_full;

	// the input stage moves on when the result slot is free or being drained
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sentence_code_q <= SENTENCE_CODE_RST;
			field_limit_q   <= FIELD_LIMIT_RST;
			char_limit_q    <= CHAR_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SENTENCE_CODE: sentence_code_q <= cfg_data;
				REG_FIELD_LIMIT:   field_limit_q   <= cfg_data[4:0];
				REG_CHAR_LIMIT:    char_limit_q    <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	// per-byte sentence update
	assign hex       = hex_decode(byte_s1);
	assign byte_sel  = {st_q.header_count[1:0] - 2'd1, 3'b000};
	assign field_inc = {1'b0, st_q.field_index} + 6'd1;
	assign sum_full  = st_q.received_sum | {4'b0000, hex[3:0]};

	always_comb begin
		nxt = st_q;
		res = '0;
		if (byte_s1 == CH_DOLLAR) begin
			// restart, any sentence in progress is dropped quietly
			nxt        = ST_CLEAR;
			nxt.active = 1'b1;
		end else if (!st_q.active) begin
			nxt = st_q;
		end else if (st_q.header_count < HDR_BYTES) begin
			// talker byte and four type bytes
			nxt.running_sum  = st_q.running_sum ^ byte_s1;
			if (st_q.header_count != 3'd0) begin
				nxt.type_word[byte_sel +: 8] = st_q.type_word[byte_sel +: 8] | byte_s1;
			end
			nxt.header_count = st_q.header_count + 3'd1;
			if (nxt.header_count == HDR_BYTES) begin
				nxt.type_ok = (nxt.type_word == sentence_code_q);
			end
		end else if (!st_q.type_ok) begin
			// not our sentence type
			nxt.active = 1'b0;
		end else if (st_q.in_checksum) begin
			if (!hex[4]) begin
				nxt.active = 1'b0;
				res = '{EV_ABORT, st_q.field_index, st_q.char_index, byte_s1, 1'b0,
					st_q.running_sum};
			end else if (!st_q.hex_high_seen) begin
				nxt.received_sum  = {hex[3:0], 4'b0000};
				nxt.hex_high_seen = 1'b1;
			end else begin
				nxt.received_sum = sum_full;
				nxt.active       = 1'b0;
				res = '{EV_SUM, st_q.field_index, 5'd0, sum_full,
					sum_full == st_q.running_sum, st_q.running_sum};
			end
		end else if (byte_s1 == CH_COMMA) begin
			// comma past the field limit, or onto the reserved index, aborts
			if (st_q.field_index == NO_FIELD - 5'd1 ||
			    (st_q.field_index != NO_FIELD && field_inc > {1'b0, field_limit_q})) begin
				nxt.active = 1'b0;
				res = '{EV_ABORT, st_q.field_index, st_q.char_index, byte_s1, 1'b0,
					st_q.running_sum};
			end else begin
				nxt.running_sum = st_q.running_sum ^ byte_s1;
				nxt.field_index = field_inc[4:0];
				nxt.char_index  = 5'd0;
				res = '{EV_END, st_q.field_index, st_q.char_index, byte_s1, 1'b0,
					st_q.running_sum ^ byte_s1};
			end
		end else if (byte_s1 == CH_STAR) begin
			// star is outside the checksum
			nxt.in_checksum   = 1'b1;
			nxt.hex_high_seen = 1'b0;
			nxt.char_index    = 5'd0;
			res = '{EV_END, st_q.field_index, st_q.char_index, byte_s1, 1'b0,
				st_q.running_sum};
		end else if (st_q.field_index == NO_FIELD || st_q.char_index > char_limit_q ||
		             byte_s1 == CH_CR || byte_s1 == CH_LF) begin
			nxt.active = 1'b0;
			res = '{EV_ABORT, st_q.field_index, st_q.char_index, byte_s1, 1'b0,
				st_q.running_sum};
		end else begin
			// plain field character, position saturates
			nxt.running_sum = st_q.running_sum ^ byte_s1;
			if (st_q.char_index != POS_MAX) begin
				nxt.char_index = st_q.char_index + 5'd1;
			end
			res = '{EV_CHAR, st_q.field_index, st_q.char_index, byte_s1, 1'b0,
				st_q.running_sum ^ byte_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
		end else if (advance) begin
			st_q <= nxt;
		end
	end

	// result register, refilled while the previous result drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.event_kind;
	assign m_tdata  = {5'b00000, res_s2.computed_sum, res_s2.checksum_match,
		res_s2.char_value, res_s2.char_position, res_s2.field_number};

`ifndef NO_ASSERTIONS
	// a checksum result or an abort always ends the sentence
	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (res.event_kind == EV_SUM || res.event_kind == EV_ABORT)
		|=> !st_q.active)
		else $error("sentence still active after checksum or abort");

	// input stalls only when both stages hold a request and the sink stalls
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && valid_s2 && !m_tready))
		else $error("input stalled without cause");

	// an empty event carries an all-zero payload
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == EV_NONE |-> m_tdata == 32'd0)
		else $error("nonzero payload on empty event");

	// field characters only appear inside an open field
	a_char_field: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == EV_CHAR |-> m_tdata[4:0] != NO_FIELD)
		else $error("field character outside a field");
`endif

endmodule
